### rtl/core/qmm_pkg.sv
package qmm_pkg;

   localparam int NUM_DIV     = 4;
   localparam int DIV_IDX_W   = 2;
   localparam int DIV_W       = 13;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int STEP_W      = 5;
   localparam int PIPE_DEPTH  = 11;

   localparam int DUTY_BASE = 2650;
   localparam int DUTY_MIN  = 2400;
   localparam int DUTY_MAX  = 4790;

   localparam logic signed [10:0] CUT_LEVEL = -11'sd850;

   localparam logic [15:0] BATT_RECIP = 16'd52429;
   localparam int          BATT_SHIFT = 20;

   localparam logic [11:0] GAIN_OFFSET  = 12'd303;
   localparam logic [6:0]  GAIN_DEFAULT = 7'd110;
   localparam logic [6:0]  GAIN_MIN     = 7'd95;
   localparam logic [6:0]  GAIN_MAX     = 7'd125;
   localparam logic [11:0] GAIN_HI_EDGE = GAIN_OFFSET - {5'd0, GAIN_MAX};
   localparam logic [11:0] GAIN_LO_EDGE = GAIN_OFFSET - {5'd0, GAIN_MIN};

   typedef logic [NUM_DIV-1:0][DIV_W-1:0]   div_array_type;
   typedef logic [NUM_DIV-1:0][RECIP_W-1:0] recip_array_type;

   typedef enum logic [DIV_IDX_W-1:0] {
      DIV_PLUS  = 2'd0,
      DIV_CROSS = 2'd1,
      DIV_YAW   = 2'd2,
      DIV_SCALE = 2'd3
   } div_sel_type;

   typedef enum logic {
      RCP_IDLE,
      RCP_RUN
   } rcp_state_type;

   typedef enum logic [2:0] {
      CSR_FRAME_MODE   = 3'd0,
      CSR_ROTOR_DIST   = 3'd1,
      CSR_DIAG_DIV     = 3'd2,
      CSR_TORQUE_RATIO = 3'd3,
      CSR_FRAME_SCALE  = 3'd4
   } csr_index_type;

endpackage

### rtl/core/quadrotor_motor_mixer.sv
// Throughput one item per cycle when not stalled by rsp_tready, the divider or a CSR write,
// set by an 11-stage pipeline with a valid bit per stage that stalls only where blocked.
// Divisions by the divisor registers use reciprocals from a shared one-bit-per-cycle divider,
// which recomputes all four after reset and after every configuration write,
// with req_tready low meanwhile. Reset is synchronous: it empties the pipeline and loads
// the register defaults.
module quadrotor_motor_mixer
   import qmm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // thrust_force, pitch_moment, roll_moment, yaw_moment, battery_level, throttle_stick
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // duty_front, duty_second, duty_third, duty_fourth
   output logic [55:0] rsp_tdata,
   // motors_cut
   output logic        rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_data
);

   // Configuration registers.
   logic        mode_ff;
   logic [11:0] rd_ff;
   logic [11:0] dd_ff;
   logic [9:0]  tr_ff;
   logic [9:0]  fs_ff;
   logic [11:0] rd_nz, dd_nz;
   logic [9:0]  tr_nz, fs_nz;
   logic        csr_write;

   div_array_type   divisors;
   recip_array_type recips;
   logic            rcp_busy;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         rd_ff   <= 12'd225;
         dd_ff   <= 12'd318;
         tr_ff   <= 10'd16;
         fs_ff   <= 10'd310;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_MODE:   mode_ff <= csr_data[0];
            CSR_ROTOR_DIST:   rd_ff   <= csr_data;
            CSR_DIAG_DIV:     dd_ff   <= csr_data;
            CSR_TORQUE_RATIO: tr_ff   <= csr_data[9:0];
            CSR_FRAME_SCALE:  fs_ff   <= csr_data[9:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rd_nz = (rd_ff == '0) ? 12'd1 : rd_ff;
      dd_nz = (dd_ff == '0) ? 12'd1 : dd_ff;
      tr_nz = (tr_ff == '0) ? 10'd1 : tr_ff;
      fs_nz = (fs_ff == '0) ? 10'd1 : fs_ff;
      divisors[DIV_PLUS]  = {rd_nz, 1'b0};
      divisors[DIV_CROSS] = {1'b0, dd_nz};
      divisors[DIV_YAW]   = {1'b0, tr_nz, 2'b00};
      divisors[DIV_SCALE] = {3'b000, fs_nz};
   end

   qmm_recip u_recip (
      .clock    (clock),
      .reset    (reset),
      .start    (csr_write),
      .divisors (divisors),
      .busy     (rcp_busy),
      .recips   (recips)
   );

   // Pipeline flow control.
   logic [PIPE_DEPTH-1:0] v_ff, v_in, en;
   logic                  req_accept;

   always_comb begin
      en[PIPE_DEPTH-1] = !v_ff[PIPE_DEPTH-1] || rsp_tready;
      for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_tready = en[0] && !rcp_busy && !csr_valid;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      v_in[0] = en[0] ? req_accept : v_ff[0];
      for (int k = 1; k < PIPE_DEPTH; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   logic [DIV_W-1:0] dab;
   assign dab = mode_ff ? divisors[DIV_CROSS] : divisors[DIV_PLUS];

   // Stage 0: mixing numerators as sign and magnitude, battery divide by 20, cutoff.
   logic signed [17:0] pitch_x, roll_x, na, nb, na_neg, nb_neg;
   logic signed [16:0] yaw_x, yaw_neg;
   logic [31:0]        bprod;
   logic [13:0]        s0_t_ff;
   logic               s0_sa_ff, s0_sb_ff, s0_sy_ff;
   logic [16:0]        s0_ma_ff, s0_mb_ff;
   logic [15:0]        s0_my_ff;
   logic [11:0]        s0_bd_ff;
   logic               s0_bz_ff, s0_cut_ff;

   always_comb begin
      pitch_x = {{2{req_tdata[31]}}, req_tdata[31:16]};
      roll_x  = {{2{req_tdata[47]}}, req_tdata[47:32]};
      yaw_x   = {req_tdata[63], req_tdata[63:48]};
      na      = mode_ff ? (roll_x - pitch_x) : -pitch_x;
      nb      = mode_ff ? (-pitch_x - roll_x) : -roll_x;
      na_neg  = -na;
      nb_neg  = -nb;
      yaw_neg = -yaw_x;
      bprod   = 32'(req_tdata[79:64]) * 32'(BATT_RECIP);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_t_ff   <= req_tdata[15:2];
         s0_sa_ff  <= na[17];
         s0_ma_ff  <= na[17] ? na_neg[16:0] : na[16:0];
         s0_sb_ff  <= nb[17];
         s0_mb_ff  <= nb[17] ? nb_neg[16:0] : nb[16:0];
         s0_sy_ff  <= req_tdata[63];
         s0_my_ff  <= req_tdata[63] ? yaw_neg[15:0] : req_tdata[63:48];
         s0_bd_ff  <= bprod[BATT_SHIFT +: 12];
         s0_bz_ff  <= (req_tdata[79:64] == '0);
         s0_cut_ff <= ($signed(req_tdata[90:80]) < CUT_LEVEL);
      end
   end

   // Stage 1: estimated quotients from the reciprocals, battery gain.
   logic [41:0] pa_full, pb_full;
   logic [40:0] py_full;
   logic [6:0]  k_in;
   logic [13:0] s1_t_ff;
   logic        s1_sa_ff, s1_sb_ff, s1_sy_ff, s1_cut_ff;
   logic [16:0] s1_ma_ff, s1_mb_ff, s1_qa_ff, s1_qb_ff;
   logic [15:0] s1_my_ff, s1_qy_ff;
   logic [6:0]  s1_k_ff;

   always_comb begin
      pa_full = 42'(s0_ma_ff) * 42'(mode_ff ? recips[DIV_CROSS] : recips[DIV_PLUS]);
      pb_full = 42'(s0_mb_ff) * 42'(mode_ff ? recips[DIV_CROSS] : recips[DIV_PLUS]);
      py_full = 41'(s0_my_ff) * 41'(recips[DIV_YAW]);
      if (s0_bz_ff) begin
         k_in = GAIN_DEFAULT;
      end else if (s0_bd_ff < GAIN_HI_EDGE) begin
         k_in = GAIN_MAX;
      end else if (s0_bd_ff > GAIN_LO_EDGE) begin
         k_in = GAIN_MIN;
      end else begin
         k_in = 7'(GAIN_OFFSET - s0_bd_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_t_ff   <= s0_t_ff;
         s1_sa_ff  <= s0_sa_ff;
         s1_sb_ff  <= s0_sb_ff;
         s1_sy_ff  <= s0_sy_ff;
         s1_ma_ff  <= s0_ma_ff;
         s1_mb_ff  <= s0_mb_ff;
         s1_my_ff  <= s0_my_ff;
         s1_qa_ff  <= pa_full[RECIP_SHIFT +: 17];
         s1_qb_ff  <= pb_full[RECIP_SHIFT +: 17];
         s1_qy_ff  <= py_full[RECIP_SHIFT +: 16];
         s1_k_ff   <= k_in;
         s1_cut_ff <= s0_cut_ff;
      end
   end

   // Stage 2: quotient times divisor for the correction step.
   logic [29:0] ba_full, bb_full;
   logic [28:0] by_full;
   logic [13:0] s2_t_ff;
   logic        s2_sa_ff, s2_sb_ff, s2_sy_ff, s2_cut_ff;
   logic [16:0] s2_ma_ff, s2_mb_ff, s2_qa_ff, s2_qb_ff, s2_ba_ff, s2_bb_ff;
   logic [15:0] s2_my_ff, s2_qy_ff, s2_by_ff;
   logic [6:0]  s2_k_ff;

   always_comb begin
      ba_full = 30'(s1_qa_ff) * 30'(dab);
      bb_full = 30'(s1_qb_ff) * 30'(dab);
      by_full = 29'(s1_qy_ff) * 29'(divisors[DIV_YAW]);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_t_ff   <= s1_t_ff;
         s2_sa_ff  <= s1_sa_ff;
         s2_sb_ff  <= s1_sb_ff;
         s2_sy_ff  <= s1_sy_ff;
         s2_ma_ff  <= s1_ma_ff;
         s2_mb_ff  <= s1_mb_ff;
         s2_my_ff  <= s1_my_ff;
         s2_qa_ff  <= s1_qa_ff;
         s2_qb_ff  <= s1_qb_ff;
         s2_qy_ff  <= s1_qy_ff;
         s2_ba_ff  <= ba_full[16:0];
         s2_bb_ff  <= bb_full[16:0];
         s2_by_ff  <= by_full[15:0];
         s2_k_ff   <= s1_k_ff;
         s2_cut_ff <= s1_cut_ff;
      end
   end

   // Stage 3: correct the quotients by one and restore their signs.
   logic [16:0]        ra, rb, qa, qb;
   logic [15:0]        ry, qy;
   logic signed [17:0] qa_x, qb_x;
   logic signed [14:0] qy_x;
   logic [13:0]        s3_t_ff;
   logic signed [17:0] s3_a_ff, s3_b_ff;
   logic signed [14:0] s3_y_ff;
   logic [6:0]         s3_k_ff;
   logic               s3_cut_ff;

   always_comb begin
      ra   = s2_ma_ff - s2_ba_ff;
      rb   = s2_mb_ff - s2_bb_ff;
      ry   = s2_my_ff - s2_by_ff;
      qa   = s2_qa_ff + 17'(ra >= 17'(dab));
      qb   = s2_qb_ff + 17'(rb >= 17'(dab));
      qy   = s2_qy_ff + 16'(ry >= 16'(divisors[DIV_YAW]));
      qa_x = {1'b0, qa};
      qb_x = {1'b0, qb};
      qy_x = {1'b0, qy[13:0]};
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_t_ff   <= s2_t_ff;
         s3_a_ff   <= s2_sa_ff ? -qa_x : qa_x;
         s3_b_ff   <= s2_sb_ff ? -qb_x : qb_x;
         s3_y_ff   <= s2_sy_ff ? -qy_x : qy_x;
         s3_k_ff   <= s2_k_ff;
         s3_cut_ff <= s2_cut_ff;
      end
   end

   // Stage 4: rotor forces.
   logic signed [17:0] tx, yx;
   logic signed [17:0] s4_f_ff [NUM_DIV];
   logic [6:0]         s4_k_ff;
   logic               s4_cut_ff;

   always_comb begin
      tx = {4'b0000, s3_t_ff};
      yx = {{3{s3_y_ff[14]}}, s3_y_ff};
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_f_ff[0] <= tx + s3_a_ff + yx;
         s4_f_ff[1] <= tx + s3_b_ff - yx;
         s4_f_ff[2] <= tx - s3_a_ff + yx;
         s4_f_ff[3] <= tx - s3_b_ff - yx;
         s4_k_ff    <= s3_k_ff;
         s4_cut_ff  <= s3_cut_ff;
      end
   end

   // Stage 5: force magnitudes.
   logic signed [17:0] f_neg [NUM_DIV];
   logic               s5_s_ff [NUM_DIV];
   logic [16:0]        s5_m_ff [NUM_DIV];
   logic [6:0]         s5_k_ff;
   logic               s5_cut_ff;

   always_comb begin
      for (int i = 0; i < NUM_DIV; i++) begin
         f_neg[i] = -s4_f_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         for (int i = 0; i < NUM_DIV; i++) begin
            s5_s_ff[i] <= s4_f_ff[i][17];
            s5_m_ff[i] <= s4_f_ff[i][17] ? f_neg[i][16:0] : s4_f_ff[i][16:0];
         end
         s5_k_ff   <= s4_k_ff;
         s5_cut_ff <= s4_cut_ff;
      end
   end

   // Stage 6: force times battery gain.
   logic       s6_s_ff [NUM_DIV];
   logic [23:0] s6_p_ff [NUM_DIV];
   logic       s6_cut_ff;

   always_ff @(posedge clock) begin
      if (en[6]) begin
         for (int i = 0; i < NUM_DIV; i++) begin
            s6_s_ff[i] <= s5_s_ff[i];
            s6_p_ff[i] <= 24'(s5_m_ff[i]) * 24'(s5_k_ff);
         end
         s6_cut_ff <= s5_cut_ff;
      end
   end

   // Stage 7: estimated quotient by frame_scale.
   logic [48:0] qf_full [NUM_DIV];
   logic        s7_s_ff [NUM_DIV];
   logic [23:0] s7_p_ff [NUM_DIV];
   logic [23:0] s7_q_ff [NUM_DIV];
   logic        s7_cut_ff;

   always_comb begin
      for (int i = 0; i < NUM_DIV; i++) begin
         qf_full[i] = 49'(s6_p_ff[i]) * 49'(recips[DIV_SCALE]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         for (int i = 0; i < NUM_DIV; i++) begin
            s7_s_ff[i] <= s6_s_ff[i];
            s7_p_ff[i] <= s6_p_ff[i];
            s7_q_ff[i] <= qf_full[i][RECIP_SHIFT +: 24];
         end
         s7_cut_ff <= s6_cut_ff;
      end
   end

   // Stage 8: quotient times frame_scale.
   logic [33:0] bf_full [NUM_DIV];
   logic        s8_s_ff [NUM_DIV];
   logic [23:0] s8_p_ff [NUM_DIV];
   logic [23:0] s8_q_ff [NUM_DIV];
   logic [23:0] s8_b_ff [NUM_DIV];
   logic        s8_cut_ff;

   always_comb begin
      for (int i = 0; i < NUM_DIV; i++) begin
         bf_full[i] = 34'(s7_q_ff[i]) * 34'(divisors[DIV_SCALE]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[8]) begin
         for (int i = 0; i < NUM_DIV; i++) begin
            s8_s_ff[i] <= s7_s_ff[i];
            s8_p_ff[i] <= s7_p_ff[i];
            s8_q_ff[i] <= s7_q_ff[i];
            s8_b_ff[i] <= bf_full[i][23:0];
         end
         s8_cut_ff <= s7_cut_ff;
      end
   end

   // Stage 9: correct the quotient and restore its sign.
   logic [23:0]        rf [NUM_DIV];
   logic [23:0]        qf [NUM_DIV];
   logic signed [24:0] qf_x [NUM_DIV];
   logic signed [24:0] s9_d_ff [NUM_DIV];
   logic               s9_cut_ff;

   always_comb begin
      for (int i = 0; i < NUM_DIV; i++) begin
         rf[i]   = s8_p_ff[i] - s8_b_ff[i];
         qf[i]   = s8_q_ff[i] + 24'(rf[i] >= 24'(divisors[DIV_SCALE]));
         qf_x[i] = {1'b0, qf[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (en[9]) begin
         for (int i = 0; i < NUM_DIV; i++) begin
            s9_d_ff[i] <= s8_s_ff[i] ? -qf_x[i] : qf_x[i];
         end
         s9_cut_ff <= s8_cut_ff;
      end
   end

   // Stage 10: add the base duty, clamp, apply the throttle cutoff.
   logic signed [25:0] dv [NUM_DIV];
   logic [12:0]        duty_in [NUM_DIV];
   logic [12:0]        s10_duty_ff [NUM_DIV];
   logic               s10_cut_ff;

   always_comb begin
      for (int i = 0; i < NUM_DIV; i++) begin
         dv[i] = {s9_d_ff[i][24], s9_d_ff[i]} + 26'(DUTY_BASE);
         if (s9_cut_ff || (dv[i] < DUTY_MIN)) begin
            duty_in[i] = 13'(DUTY_MIN);
         end else if (dv[i] > DUTY_MAX) begin
            duty_in[i] = 13'(DUTY_MAX);
         end else begin
            duty_in[i] = dv[i][12:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[10]) begin
         for (int i = 0; i < NUM_DIV; i++) begin
            s10_duty_ff[i] <= duty_in[i];
         end
         s10_cut_ff <= s9_cut_ff;
      end
   end

   assign rsp_tvalid = v_ff[PIPE_DEPTH-1];
   assign rsp_tdata  = {4'b0000, s10_duty_ff[3], s10_duty_ff[2], s10_duty_ff[1],
                        s10_duty_ff[0]};
   assign rsp_tuser  = s10_cut_ff;

endmodule

### rtl/core/qmm_recip.sv
module qmm_recip
   import qmm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  div_array_type   divisors,
   output logic            busy,
   output recip_array_type recips
);

   rcp_state_type          state_ff, state_in;
   logic [DIV_IDX_W-1:0]   idx_ff, idx_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [DIV_W-1:0]       rem_ff, rem_in;
   logic [RECIP_W-1:0]     quo_ff, quo_in;
   recip_array_type        recips_ff, recips_in;
   logic [DIV_W:0]         rem_sh;
   logic [DIV_W:0]         dcur;
   logic                   qbit;

   // Restoring division of 2^24 by each divisor in turn, one quotient bit per cycle.
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      step_in   = step_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      recips_in = recips_ff;
      dcur      = {1'b0, divisors[idx_ff]};
      rem_sh    = {rem_ff, (step_ff == STEP_W'(RECIP_SHIFT))};
      qbit      = (rem_sh >= dcur);
      case (state_ff)
         RCP_IDLE: begin
            state_in = RCP_IDLE;
         end
         RCP_RUN: begin
            rem_in = qbit ? DIV_W'(rem_sh - dcur) : rem_sh[DIV_W-1:0];
            quo_in = {quo_ff[RECIP_W-2:0], qbit};
            if (step_ff == '0) begin
               recips_in[idx_ff] = quo_in;
               rem_in  = '0;
               step_in = STEP_W'(RECIP_SHIFT);
               idx_in  = idx_ff + DIV_IDX_W'(1);
               if (idx_ff == DIV_IDX_W'(NUM_DIV - 1)) begin
                  state_in = RCP_IDLE;
               end
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         default: begin
            state_in = RCP_IDLE;
         end
      endcase
      if (start) begin
         state_in = RCP_RUN;
         idx_in   = '0;
         step_in  = STEP_W'(RECIP_SHIFT);
         rem_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RCP_RUN;
         idx_ff   <= '0;
         step_ff  <= STEP_W'(RECIP_SHIFT);
         rem_ff   <= '0;
         quo_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         step_ff  <= step_in;
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      recips_ff <= recips_in;
   end

   assign busy   = (state_ff == RCP_RUN);
   assign recips = recips_ff;

endmodule
